[hdl/mcwd_pkg.sv]
// Shared types, opcode codes, step templates and register code functions for the decoder.
package mcwd_pkg;

   localparam int unsigned ADDR_W = 14;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned STEPS  = 8;

   typedef struct packed {
      logic [2:0] reg1;
      logic [2:0] reg0;
      logic       imm;
      logic [3:0] opcode;
      logic [2:0] step;
   } addr_type;

   typedef enum logic [3:0] {
      OP_MOVE  = 4'd0,
      OP_LOAD  = 4'd1,
      OP_STORE = 4'd2,
      OP_PUSH  = 4'd3,
      OP_POP   = 4'd4,
      OP_LDA   = 4'd5,
      OP_JUMP  = 4'd6
   } opcode_type;

   typedef enum logic [3:0] {
      T_MW_REG   = 4'd0,
      T_MW_IMM   = 4'd1,
      T_LW_MAR   = 4'd2,
      T_LW_IMM   = 4'd3,
      T_SW_MAR   = 4'd4,
      T_SW_IMM   = 4'd5,
      T_PUSH_REG = 4'd6,
      T_PUSH_IMM = 4'd7,
      T_POP      = 4'd8,
      T_LDA      = 4'd9,
      T_JNZ      = 4'd10,
      T_JC       = 4'd11,
      T_JEQ      = 4'd12,
      T_JMP      = 4'd13
   } tmpl_type;

   localparam int unsigned TMPL_COUNT = 14;

   localparam logic [2:0] SEL_NONE     = 3'd7;
   localparam logic [2:0] SEL_MAR_LOW  = 3'd5;
   localparam logic [2:0] SEL_MAR_HIGH = 3'd6;
   localparam logic [2:0] SEL_A        = 3'd0;
   localparam logic [2:0] SEL_B        = 3'd1;

   localparam logic [2:0] STEP_1 = 3'd1;
   localparam logic [2:0] STEP_2 = 3'd2;
   localparam logic [2:0] STEP_3 = 3'd3;
   localparam logic [2:0] STEP_5 = 3'd5;

   localparam logic [WORD_W-1:0] RST_WORD   = 16'h000F;
   localparam logic [WORD_W-1:0] COUNT_WORD = 16'h0400;

   localparam logic [WORD_W-1:0] TEMPLATE [TMPL_COUNT][STEPS] = '{
      '{16'h0358, 16'h0400, 16'h0398, 16'h0400, RST_WORD, RST_WORD, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0400, 16'h0018, 16'h0400, RST_WORD, RST_WORD, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0028, 16'h0400, RST_WORD, RST_WORD, RST_WORD, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0400, 16'h0198, 16'h0400, 16'h01D8, 16'h0428, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0620, RST_WORD, RST_WORD, RST_WORD, RST_WORD, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0400, 16'h0198, 16'h0400, 16'h01D8, 16'h0620, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0630, 16'h1000, RST_WORD, RST_WORD, RST_WORD, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0400, 16'h0398, 16'h063B, 16'h1000, RST_WORD, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0438, 16'h0C00, RST_WORD, RST_WORD, RST_WORD, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0400, 16'h0198, 16'h0400, 16'h01D8, 16'h0400, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0440, 16'h1676, 16'h16B7, RST_WORD, RST_WORD, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0400, 16'h1E76, 16'h1EB7, RST_WORD, RST_WORD, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0400, 16'h1A76, 16'h1AB7, RST_WORD, RST_WORD, RST_WORD, RST_WORD},
      '{16'h0358, 16'h0276, 16'h02B7, RST_WORD, RST_WORD, RST_WORD, RST_WORD, RST_WORD}
   };

   function automatic logic [WORD_W-1:0] wr_code(input logic [2:0] sel);
      logic [WORD_W-1:0] code;
      code = '0;
      if (sel != SEL_NONE) begin
         code[9:6] = {1'b0, sel} + 4'd1;
      end
      return code;
   endfunction

   function automatic logic [WORD_W-1:0] out_code(input logic [2:0] sel);
      logic [WORD_W-1:0] code;
      code = '0;
      if (sel != SEL_NONE) begin
         code[3:0] = {1'b0, sel} + 4'd1;
         if (sel == SEL_MAR_LOW || sel == SEL_MAR_HIGH) begin
            code[5:4] = 2'd2;
         end
      end
      return code;
   endfunction

endpackage

[hdl/mcwd_if.sv]
// Valid/ready channel interfaces for the address and control word beats.
interface mcwd_req_if;
   logic                           valid;
   logic                           ready;
   logic [mcwd_pkg::ADDR_W-1:0]    micro_address;

   modport source (output valid, output micro_address, input ready);
   modport sink   (input valid, input micro_address, output ready);
endinterface

interface mcwd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mcwd_pkg::WORD_W-1:0]    control_word;

   modport source (output valid, output control_word, input ready);
   modport sink   (input valid, input control_word, output ready);
endinterface

[hdl/microcode_control_word_decoder.sv]
// Microcode control store: address beat in, one control word beat out.
//
// req_bus carries a 14-bit micro_address (step, opcode, imm, reg0, reg1);
// rsp_bus returns the 16-bit control_word for it, one word per address.
// Both channels move a beat when valid and ready are high at a clock edge.
// The address is captured in an input register, decoded by a template
// table lookup with register codes ORed in, and the word lands in an output
// register, which drives rsp_bus.valid and rsp_bus.control_word.
// Throughput is one beat per cycle; the input register hands over to the
// output register whenever the output is empty or being taken, so a new
// address is accepted in every cycle while rsp_bus keeps up.
// When the receiver holds rsp_bus.ready low, the output register holds its
// word, the input register fills, and req_bus.ready then drops until the
// word is taken; nothing is lost or repeated.
// Synchronous reset empties both registers; the decoder keeps no other state.
module microcode_control_word_decoder (
   input  logic           clock,
   input  logic           reset,
   mcwd_req_if.sink       req_bus,
   mcwd_rsp_if.source     rsp_bus
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic [mcwd_pkg::ADDR_W-1:0]   in_addr_ff;
   logic [mcwd_pkg::ADDR_W-1:0]   in_addr_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [mcwd_pkg::WORD_W-1:0]   out_word_ff;
   logic [mcwd_pkg::WORD_W-1:0]   out_word_in;
   logic [mcwd_pkg::WORD_W-1:0]   word;
   logic                          out_open;
   logic                          advance;
   logic                          take;

   mcwd_decode u_decode (
      .micro_address (in_addr_ff),
      .control_word  (word)
   );

   assign out_open = !out_valid_ff || rsp_bus.ready;
   assign advance  = in_valid_ff && out_open;
   assign req_bus.ready = !in_valid_ff || out_open;
   assign take     = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_addr_in   = in_addr_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (out_open) begin
         out_valid_in = in_valid_ff;
         out_word_in  = word;
      end
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         if (take) begin
            in_addr_in = req_bus.micro_address;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_addr_ff  <= in_addr_in;
      out_word_ff <= advance ? out_word_in : out_word_ff;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.control_word = out_word_ff;

endmodule

[hdl/mcwd_decode.sv]
// Combinational control word lookup from a registered microcode address.
module mcwd_decode (
   input  logic [mcwd_pkg::ADDR_W-1:0] micro_address,
   output logic [mcwd_pkg::WORD_W-1:0] control_word
);

   mcwd_pkg::addr_type            addr;
   mcwd_pkg::tmpl_type            tsel;
   logic [mcwd_pkg::WORD_W-1:0]   patch;
   logic                          known;
   logic                          count_only;

   assign addr = mcwd_pkg::addr_type'(micro_address);

   always_comb begin
      tsel       = mcwd_pkg::T_MW_REG;
      patch      = '0;
      known      = 1'b1;
      count_only = 1'b0;
      case (addr.opcode)
         mcwd_pkg::OP_MOVE: begin
            if (!addr.imm) begin
               tsel = mcwd_pkg::T_MW_REG;
               if (addr.step == mcwd_pkg::STEP_3) begin
                  patch = mcwd_pkg::out_code(addr.reg1) | mcwd_pkg::wr_code(addr.reg0);
               end
            end else begin
               tsel = mcwd_pkg::T_MW_IMM;
               if (addr.step == mcwd_pkg::STEP_2) begin
                  patch = mcwd_pkg::wr_code(addr.reg0);
               end
            end
         end
         mcwd_pkg::OP_LOAD: begin
            if (!addr.imm) begin
               tsel = mcwd_pkg::T_LW_MAR;
               if (addr.step == mcwd_pkg::STEP_1) begin
                  patch = mcwd_pkg::wr_code(addr.reg0);
               end
            end else begin
               tsel = mcwd_pkg::T_LW_IMM;
               if (addr.step == mcwd_pkg::STEP_5) begin
                  patch = mcwd_pkg::wr_code(addr.reg0);
               end
            end
         end
         mcwd_pkg::OP_STORE: begin
            if (!addr.imm) begin
               tsel = mcwd_pkg::T_SW_MAR;
               if (addr.step == mcwd_pkg::STEP_1) begin
                  patch = mcwd_pkg::out_code(addr.reg0);
               end
            end else begin
               tsel = mcwd_pkg::T_SW_IMM;
               if (addr.step == mcwd_pkg::STEP_5) begin
                  patch = mcwd_pkg::out_code(addr.reg0);
               end
            end
         end
         mcwd_pkg::OP_PUSH: begin
            if (!addr.imm) begin
               tsel = mcwd_pkg::T_PUSH_REG;
               if (addr.step == mcwd_pkg::STEP_1) begin
                  patch = mcwd_pkg::out_code(addr.reg0);
               end
            end else begin
               tsel = mcwd_pkg::T_PUSH_IMM;
            end
         end
         mcwd_pkg::OP_POP: begin
            tsel = mcwd_pkg::T_POP;
            if (addr.step == mcwd_pkg::STEP_1) begin
               patch = mcwd_pkg::wr_code(addr.reg0);
            end
         end
         mcwd_pkg::OP_LDA: begin
            tsel = mcwd_pkg::T_LDA;
         end
         mcwd_pkg::OP_JUMP: begin
            if (!addr.imm) begin
               tsel = mcwd_pkg::T_JNZ;
               if (addr.step == mcwd_pkg::STEP_1) begin
                  if (addr.reg0 == mcwd_pkg::SEL_A) begin
                     count_only = 1'b1;
                  end else begin
                     patch = mcwd_pkg::out_code(addr.reg0);
                  end
               end
            end else if (addr.reg0 == mcwd_pkg::SEL_A) begin
               tsel = mcwd_pkg::T_JC;
            end else if (addr.reg0 == mcwd_pkg::SEL_B) begin
               tsel = mcwd_pkg::T_JEQ;
            end else begin
               tsel = mcwd_pkg::T_JMP;
            end
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (!known) begin
         control_word = '0;
      end else if (count_only) begin
         control_word = mcwd_pkg::COUNT_WORD;
      end else begin
         control_word = mcwd_pkg::TEMPLATE[tsel][addr.step] | patch;
      end
   end

endmodule
